// ===== hdl/gsa_pkg.sv =====
// shared types and constants of the global sequence alignment score block
package gsa_pkg;

  localparam int unsigned LABEL_W = 6;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned FRAC_W  = 17;
  localparam int unsigned RAW_W   = 9;
  localparam int unsigned QCNT_W  = 5;

  localparam logic [CMD_W-1:0] CMD_APPEND_A = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND_B = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MARK     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_COMPUTE  = 3'd4;

  localparam int MATCH_PTS    = 2;
  localparam int MISMATCH_PTS = -1;
  localparam int GAP_PTS      = -1;

  localparam logic [FRAC_W-1:0] ONE_Q16  = 17'h10000;
  localparam logic [QCNT_W-1:0] DIV_LAST = 5'd16;

  localparam logic signed [RAW_W-1:0] RAW_MAX = 9'sd255;
  localparam logic signed [RAW_W-1:0] RAW_MIN = -9'sd256;

  // token that moves along the cell chain with each A symbol
  typedef struct packed {
    logic vld;
    logic last;
  } gsa_tok_t;

endpackage

// ===== hdl/global_sequence_alignment_score.sv =====
// top level of the global sequence alignment score block
//
// usage
//   slave channel: one beat per command; tuser carries the command, tdata the
//   labels. appends of A and B symbols and a clear of the equivalences are
//   taken in idle; a mark is a read-modify-write of row x, then of row y.
//   master channel: one beat per compute command with the fraction, the raw
//   score and the overflow flag.
// compute
//   with both sequences non-empty, a compute runs A through a chain of MAX_LEN
//   cells, one cell per B symbol; then a restoring divider forms the Q1.16
//   fraction, which is loaded into the output register.
//   tready stays low from the compute beat until the result is registered.
// reset
//   lengths, drop flag and all equivalence row valid bits clear at once; the
//   equivalence rows themselves are not swept, an invalid row reads as zero.
// stall
//   the result waits in the output register; further loads and marks are taken
//   meanwhile, and a second compute holds its result until the first is taken.
module global_sequence_alignment_score #(
  parameter int unsigned MAX_LEN    = 64,
  parameter int unsigned NUM_LABELS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // label [5:0], partner_label [11:6]
  input  logic [2:0]  s_axis_tuser,   // cmd [2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // score_fraction [16:0], raw_score [25:17]
  output logic [0:0]  m_axis_tuser    // overflowed [0]
);

  localparam int unsigned LW  = $clog2(MAX_LEN + 1);
  localparam int unsigned AIW = MAX_LEN > 1 ? $clog2(MAX_LEN) : 1;
  localparam int unsigned LBW = $clog2(NUM_LABELS);
  localparam int unsigned SW  = ($clog2(MAX_LEN) + 3 < 10) ? 10 : $clog2(MAX_LEN) + 3;
  localparam int unsigned DW  = LW + 1;
  localparam int unsigned LAB = gsa_pkg::LABEL_W;

  // sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MK_RDX = 4'd1;
  localparam logic [3:0] ST_MK_WRX = 4'd2;
  localparam logic [3:0] ST_MK_RDY = 4'd3;
  localparam logic [3:0] ST_MK_WRY = 4'd4;
  localparam logic [3:0] ST_FEED   = 4'd5;
  localparam logic [3:0] ST_WAIT   = 4'd6;
  localparam logic [3:0] ST_DIV    = 4'd7;
  localparam logic [3:0] ST_OUT    = 4'd8;

  logic [3:0] state_q, state_d;

  // input beat fields
  logic [2:0]     cmd;
  logic [LAB-1:0] lab, partner;
  logic           s_acc;
  assign cmd     = s_axis_tuser;
  assign lab     = s_axis_tdata[5:0];
  assign partner = s_axis_tdata[11:6];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc   = s_axis_tvalid && s_axis_tready;

  logic [LW-1:0] len_a_q, len_a_d, len_b_q, len_b_d;
  logic          drop_q, drop_d;

  // equivalence rows, symmetric: a mark sets both (x,y) and (y,x)
  logic [NUM_LABELS-1:0] row_vld_q, row_vld_d;
  logic [LAB-1:0]        mx_q, mx_d, my_q, my_d;
  logic                  eq_we;
  logic [LBW-1:0]        eq_waddr, eq_raddr;
  logic [NUM_LABELS-1:0] eq_wdata, eq_rdata;
  logic [15:0]           mx_ext, my_ext;

  // A store
  logic           a_we;
  logic [AIW-1:0] a_raddr;
  logic [LAB-1:0] a_rdata;

  // feed pipeline
  logic [LW-1:0]  k_q, k_d;
  logic           s1_vld_q, s1_last_q;
  logic [LW-1:0]  s1_idx_q;
  logic           s2_vld_q, s2_last_q, s2_inrng_q;
  logic [LW-1:0]  s2_idx_q;
  logic [LAB-1:0] s2_a_q;
  logic [15:0]    a_ext;
  logic           a_inrng;

  // result and divider
  logic signed [SW-1:0] raw_q, raw_d;
  logic [DW-1:0]        rem_q, rem_d;
  logic [gsa_pkg::FRAC_W-1:0] quo_q, quo_d;
  logic [gsa_pkg::QCNT_W-1:0] cnt_q, cnt_d;
  logic [LW-1:0]        longest;
  logic [DW-1:0]        den;
  logic [DW:0]          div_t;
  logic                 div_ge;

  logic                       out_vld_q, out_vld_d;
  logic [gsa_pkg::FRAC_W-1:0] out_frac_q, out_frac_d;
  logic [gsa_pkg::RAW_W-1:0]  out_raw_q, out_raw_d;
  logic                       out_ovf_q, out_ovf_d;
  logic                       out_load;

  logic start;

  // cell chain links, index 0 is the chain input
  gsa_pkg::gsa_tok_t     tok_a [MAX_LEN+1];
  logic [LAB-1:0]        sym_a [MAX_LEN+1];
  logic [NUM_LABELS-1:0] vec_a [MAX_LEN+1];
  logic signed [SW-1:0]  d_a   [MAX_LEN+1];

  gsa_pkg::gsa_tok_t    sel_tok;
  logic signed [SW-1:0] sel_d;

  assign mx_ext = 16'(mx_q);
  assign my_ext = 16'(my_q);
  assign a_ext  = 16'(a_rdata);
  assign a_inrng = (a_ext < 16'(NUM_LABELS)) && row_vld_q[a_ext[LBW-1:0]];

  assign longest = (len_a_q > len_b_q) ? len_a_q : len_b_q;
  assign den     = {longest, 1'b0};
  assign div_t   = (cnt_q == '0) ? raw_q[DW:0] : {rem_q, 1'b0};
  assign div_ge  = div_t >= {1'b0, den};

  // output link of the last used cell, the one holding B symbol len_b - 1
  assign sel_tok = tok_a[len_b_q];
  assign sel_d   = d_a[len_b_q];

  assign a_we    = s_acc && (cmd == gsa_pkg::CMD_APPEND_A) && (len_a_q < LW'(MAX_LEN));
  assign a_raddr = k_q[AIW-1:0];
  assign start   = s_acc && (cmd == gsa_pkg::CMD_COMPUTE) &&
                   (len_a_q != '0) && (len_b_q != '0);
  assign out_load = !out_vld_q || m_axis_tready;

  // equivalence row port control
  always_comb begin
    eq_we    = 1'b0;
    eq_waddr = mx_ext[LBW-1:0];
    eq_wdata = NUM_LABELS'(1) << my_ext[LBW-1:0];
    eq_raddr = a_ext[LBW-1:0];
    unique case (state_q)
      ST_MK_RDX: eq_raddr = mx_ext[LBW-1:0];
      ST_MK_RDY: eq_raddr = my_ext[LBW-1:0];
      ST_MK_WRX: begin
        eq_we    = 1'b1;
        eq_wdata = (row_vld_q[mx_ext[LBW-1:0]] ? eq_rdata : '0) |
                   (NUM_LABELS'(1) << my_ext[LBW-1:0]);
      end
      ST_MK_WRY: begin
        eq_we    = 1'b1;
        eq_waddr = my_ext[LBW-1:0];
        eq_wdata = (row_vld_q[my_ext[LBW-1:0]] ? eq_rdata : '0) |
                   (NUM_LABELS'(1) << mx_ext[LBW-1:0]);
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    len_a_d    = len_a_q;
    len_b_d    = len_b_q;
    drop_d     = drop_q;
    row_vld_d  = row_vld_q;
    mx_d       = mx_q;
    my_d       = my_q;
    k_d        = k_q;
    raw_d      = raw_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    cnt_d      = cnt_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_frac_d = out_frac_q;
    out_raw_d  = out_raw_q;
    out_ovf_d  = out_ovf_q;

    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          case (cmd)
            gsa_pkg::CMD_APPEND_A: begin
              if (len_a_q < LW'(MAX_LEN)) len_a_d = len_a_q + LW'(1);
              else                        drop_d  = 1'b1;
            end
            gsa_pkg::CMD_APPEND_B: begin
              if (len_b_q < LW'(MAX_LEN)) len_b_d = len_b_q + LW'(1);
              else                        drop_d  = 1'b1;
            end
            gsa_pkg::CMD_MARK: begin
              mx_d = lab;
              my_d = partner;
              if ((16'(lab) < 16'(NUM_LABELS)) && (16'(partner) < 16'(NUM_LABELS))) begin
                state_d = ST_MK_RDX;
              end
            end
            gsa_pkg::CMD_CLEAR: row_vld_d = '0;
            gsa_pkg::CMD_COMPUTE: begin
              cnt_d = '0;
              if (start) begin
                k_d     = '0;
                state_d = ST_FEED;
              end else begin
                // one side empty: score is minus the other length
                raw_d   = SW'(0) - SW'(len_a_q) - SW'(len_b_q);
                state_d = ST_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MK_RDX: state_d = ST_MK_WRX;
      ST_MK_WRX: begin
        row_vld_d[mx_ext[LBW-1:0]] = 1'b1;
        state_d = ST_MK_RDY;
      end
      ST_MK_RDY: state_d = ST_MK_WRY;
      ST_MK_WRY: begin
        row_vld_d[my_ext[LBW-1:0]] = 1'b1;
        state_d = ST_IDLE;
      end
      ST_FEED: begin
        k_d = k_q + LW'(1);
        if (k_q == len_a_q - LW'(1)) state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (sel_tok.vld && sel_tok.last) begin
          raw_d   = sel_d;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        // restoring division, one quotient bit per cycle
        rem_d = div_ge ? DW'(div_t - {1'b0, den}) : div_t[DW-1:0];
        quo_d = {quo_q[gsa_pkg::FRAC_W-2:0], div_ge};
        cnt_d = cnt_q + gsa_pkg::QCNT_W'(1);
        if (cnt_q == gsa_pkg::DIV_LAST) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          out_vld_d = 1'b1;
          if (longest == '0)                 out_frac_d = gsa_pkg::ONE_Q16;
          else if (raw_q <= SW'(0))          out_frac_d = '0;
          else                               out_frac_d = quo_q;
          if (raw_q > SW'(gsa_pkg::RAW_MAX))      out_raw_d = gsa_pkg::RAW_MAX;
          else if (raw_q < SW'(gsa_pkg::RAW_MIN)) out_raw_d = gsa_pkg::RAW_MIN;
          else                                    out_raw_d = raw_q[gsa_pkg::RAW_W-1:0];
          out_ovf_d = drop_q;
          drop_d    = 1'b0;
          len_a_d   = '0;
          len_b_d   = '0;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      len_a_q   <= '0;
      len_b_q   <= '0;
      drop_q    <= 1'b0;
      row_vld_q <= '0;
      out_vld_q <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      k_q       <= '0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      len_a_q   <= len_a_d;
      len_b_q   <= len_b_d;
      drop_q    <= drop_d;
      row_vld_q <= row_vld_d;
      out_vld_q <= out_vld_d;
      s1_vld_q  <= (state_q == ST_FEED);
      s2_vld_q  <= s1_vld_q;
      k_q       <= k_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q       <= mx_d;
    my_q       <= my_d;
    raw_q      <= raw_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    out_frac_q <= out_frac_d;
    out_raw_q  <= out_raw_d;
    out_ovf_q  <= out_ovf_d;
    s1_last_q  <= (k_q == len_a_q - LW'(1));
    s1_idx_q   <= k_q + LW'(1);
    s2_last_q  <= s1_last_q;
    s2_idx_q   <= s1_idx_q;
    s2_a_q     <= a_rdata;
    s2_inrng_q <= a_inrng;
  end

  gsa_ram #(.WIDTH(LAB), .DEPTH(MAX_LEN)) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (len_a_q[AIW-1:0]),
    .wdata_i (lab),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  gsa_ram #(.WIDTH(NUM_LABELS), .DEPTH(NUM_LABELS)) u_eq_ram (
    .clk_i   (clk_i),
    .we_i    (eq_we),
    .waddr_i (eq_waddr),
    .wdata_i (eq_wdata),
    .raddr_i (eq_raddr),
    .rdata_o (eq_rdata)
  );

  // chain input: row i of the matrix enters with its left border value -i
  assign tok_a[0] = '{vld: s2_vld_q, last: s2_last_q};
  assign sym_a[0] = s2_a_q;
  assign vec_a[0] = s2_inrng_q ? eq_rdata : '0;
  assign d_a[0]   = SW'(0) - SW'(s2_idx_q);

  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    gsa_cell #(.SW(SW), .NL(NUM_LABELS), .COL(j)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (start),
      .wr_en_i    (s_acc && (cmd == gsa_pkg::CMD_APPEND_B) && (len_b_q == LW'(j))),
      .wr_label_i (lab),
      .tok_i      (tok_a[j]),
      .a_i        (sym_a[j]),
      .vec_i      (vec_a[j]),
      .d_i        (d_a[j]),
      .tok_o      (tok_a[j+1]),
      .a_o        (sym_a[j+1]),
      .vec_o      (vec_a[j+1]),
      .d_o        (d_a[j+1])
    );
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, out_raw_q, out_frac_q};
  assign m_axis_tuser  = out_ovf_q;

endmodule

// ===== hdl/gsa_ram.sv =====
// generic single write port memory with registered read
module gsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/gsa_cell.sv =====
// one column of the alignment matrix: holds a B symbol and the running column value
module gsa_cell #(
  parameter int unsigned SW  = 10,
  parameter int unsigned NL  = 64,
  parameter int unsigned COL = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          wr_en_i,
  input  logic [gsa_pkg::LABEL_W-1:0]   wr_label_i,
  input  gsa_pkg::gsa_tok_t             tok_i,
  input  logic [gsa_pkg::LABEL_W-1:0]   a_i,
  input  logic [NL-1:0]                 vec_i,
  input  logic signed [SW-1:0]          d_i,
  output gsa_pkg::gsa_tok_t             tok_o,
  output logic [gsa_pkg::LABEL_W-1:0]   a_o,
  output logic [NL-1:0]                 vec_o,
  output logic signed [SW-1:0]          d_o
);

  localparam int unsigned LBW = $clog2(NL);
  localparam logic signed [SW-1:0] INIT_UP   = SW'(-(int'(COL) + 1));
  localparam logic signed [SW-1:0] INIT_DIAG = SW'(-int'(COL));

  logic [gsa_pkg::LABEL_W-1:0] b_q;
  logic signed [SW-1:0]        up_q, diag_q;
  logic [15:0]                 b_ext;
  logic                        match;
  logic signed [SW-1:0]        diag_s, up_s, left_s, best;

  always_comb begin
    b_ext  = 16'(b_q);
    match  = (a_i == b_q) || ((b_ext < 16'(NL)) && vec_i[b_ext[LBW-1:0]]);
    diag_s = match ? diag_q + SW'(gsa_pkg::MATCH_PTS) : diag_q + SW'(gsa_pkg::MISMATCH_PTS);
    up_s   = up_q + SW'(gsa_pkg::GAP_PTS);
    left_s = d_i + SW'(gsa_pkg::GAP_PTS);
    best   = diag_s;
    if (up_s > best) begin
      best = up_s;
    end
    if (left_s > best) begin
      best = left_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_o <= '0;
    end else if (start_i) begin
      tok_o <= '0;
    end else begin
      tok_o <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      b_q <= wr_label_i;
    end
    if (start_i) begin
      up_q   <= INIT_UP;
      diag_q <= INIT_DIAG;
    end else if (tok_i.vld) begin
      up_q   <= best;
      diag_q <= d_i;
      a_o    <= a_i;
      vec_o  <= vec_i;
      d_o    <= best;
    end
  end

endmodule

// ===== hdl/gsa_checker.sv =====
// port-level checks of the global sequence alignment score block
module gsa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == gsa_pkg::CMD_COMPUTE)
    |=> !s_axis_tready)
    else $error("input taken right after compute");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[16:0] <= gsa_pkg::ONE_Q16)
    else $error("fraction above one");

  a_neg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[25] |-> m_axis_tdata[16:0] == '0)
    else $error("negative score with nonzero fraction");

endmodule

bind global_sequence_alignment_score gsa_checker u_gsa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
